>>> hw/rtl/sbp_pkg.sv
// ----------------------------------------------------------------------------
// sbp_pkg: shebang line parser shared types and constants
// Phase codes, verdict codes, register indexes and the result record.
// ----------------------------------------------------------------------------
package sbp_pkg;

	localparam int BYTE_W  = 8;
	localparam int CAP_W   = 8;
	localparam int CFG_IDX_W = 1;

	localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
	localparam logic [BYTE_W-1:0] CH_BANG  = 8'h21;
	localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

	typedef enum logic [2:0] {
		PH_HASH   = 3'd0,
		PH_BANG   = 3'd1,
		PH_LEAD   = 3'd2,
		PH_INTERP = 3'd3,
		PH_MID    = 3'd4,
		PH_ARG    = 3'd5,
		PH_TRAIL  = 3'd6,
		PH_IGNORE = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		VERDICT_NOT_SHEBANG = 2'd0,
		VERDICT_INTERP_ONLY = 2'd1,
		VERDICT_WITH_ARG    = 2'd2,
		VERDICT_MALFORMED   = 2'd3
	} verdict_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INTERP_CAP = 1'b0,
		CFG_ARG_CAP    = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic              tok_valid;
		logic              tok_arg;
		logic [BYTE_W-1:0] tok_byte;
		logic              ver_valid;
		verdict_t          verdict;
	} result_t;

endpackage

>>> hw/rtl/sbp_if.sv
// ----------------------------------------------------------------------------
// sbp_if: shebang line parser channels
// Valid/ready channels for input bytes and parse results.
// ----------------------------------------------------------------------------
interface sbp_line_if;
	logic       valid;
	logic       ready;
	logic [7:0] line_byte;
	logic       line_end;

	modport source (output valid, output line_byte, output line_end, input ready);
	modport sink   (input valid, input line_byte, input line_end, output ready);
endinterface

interface sbp_result_if;
	logic       valid;
	logic       ready;
	logic       token_valid;
	logic       token_is_argument;
	logic [7:0] token_byte;
	logic       verdict_valid;
	logic [1:0] verdict;

	modport source (output valid, output token_valid, output token_is_argument,
		output token_byte, output verdict_valid, output verdict, input ready);
	modport sink   (input valid, input token_valid, input token_is_argument,
		input token_byte, input verdict_valid, input verdict, output ready);
endinterface

>>> hw/rtl/shebang_line_parser.sv
// ----------------------------------------------------------------------------
// shebang_line_parser: interpreter line parser
// Checks for "#!", streams interpreter and argument bytes, gives one verdict.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                          | handshake
//  line     | in  | line_byte, line_end                              | valid/ready
//  result   | out | token_valid, token_is_argument, token_byte,      | valid/ready
//           |     | verdict_valid, verdict                           |
//  config   | in  | wr_index, wr_data                                | wr_en
//
//  One item per cycle unless a stalled result holds the flow: input register, phase decode, result register.
//  A line item passes through the input register, then its result through the result register.
//  Items that yield no result retire without waiting on the result side.
//  A stalled result holds while one more item waits in the input register.
//  Reset returns to awaiting '#' with both capacities at 128.
// ----------------------------------------------------------------------------
module shebang_line_parser #(
	parameter int LINE_MAX = 128
) (
	input  logic                            clk,
	input  logic                            arst_n,
	sbp_line_if.sink                        line,
	sbp_result_if.source                    result,
	input  logic                            wr_en,
	input  logic [sbp_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [sbp_pkg::CAP_W-1:0]       wr_data
);
	import sbp_pkg::*;

	logic [CAP_W-1:0]  interp_cap_q, arg_cap_q;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              end_s1;
	logic              out_valid_q;
	result_t           res_q;
	result_t           res;
	logic              has_result, advance;

	assign has_result = res.tok_valid || res.ver_valid;
	assign advance    = valid_s1 && (!has_result || !out_valid_q || result.ready);
	assign line.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interp_cap_q <= CAP_W'(128);
			arg_cap_q    <= CAP_W'(128);
		end else if (wr_en) begin
			unique case (cfg_index_t'(wr_index))
				CFG_INTERP_CAP: interp_cap_q <= wr_data;
				CFG_ARG_CAP:    arg_cap_q    <= wr_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (line.ready) begin
			valid_s1 <= line.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (line.valid && line.ready) begin
			byte_s1 <= line.line_byte;
			end_s1  <= line.line_end;
		end
	end

	sbp_core #(
		.LINE_MAX (LINE_MAX)
	) u_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.advance           (advance),
		.line_byte         (byte_s1),
		.line_end          (end_s1),
		.interp_capacity   (interp_cap_q),
		.argument_capacity (arg_cap_q),
		.result            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result.ready || !out_valid_q) begin
			out_valid_q <= advance && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			res_q <= res;
		end
	end

	assign result.valid             = out_valid_q;
	assign result.token_valid       = res_q.tok_valid;
	assign result.token_is_argument = res_q.tok_arg;
	assign result.token_byte        = res_q.tok_byte;
	assign result.verdict_valid     = res_q.ver_valid;
	assign result.verdict           = res_q.verdict;

endmodule

>>> hw/rtl/sbp_core.sv
// ----------------------------------------------------------------------------
// sbp_core: shebang line phase machine
// Holds phase, token length and line position; decodes one byte per cycle.
// ----------------------------------------------------------------------------
module sbp_core #(
	parameter int LINE_MAX = 128
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  logic [sbp_pkg::BYTE_W-1:0]   line_byte,
	input  logic                         line_end,
	input  logic [sbp_pkg::CAP_W-1:0]    interp_capacity,
	input  logic [sbp_pkg::CAP_W-1:0]    argument_capacity,
	output sbp_pkg::result_t             result
);
	import sbp_pkg::*;

	localparam int PW  = $clog2(LINE_MAX + 1);
	localparam int PW1 = PW + 1;
	localparam logic [PW-1:0]  POS_MAX = PW'(LINE_MAX);
	localparam logic [PW:0]    END_POS = PW1'(LINE_MAX - 1);

	phase_t                phase_q, phase_d;
	logic [CAP_W-1:0]      len_q, len_d;
	logic [PW-1:0]         pos_q, pos_d;

	logic                  at_end, blank, stop, app, app_arg, too_long;
	logic [CAP_W-1:0]      len_base, cap;

	assign at_end = line_end || (({1'b0, pos_q} + PW1'(1)) >= END_POS);
	assign blank  = (line_byte == CH_SPACE) || (line_byte == CH_TAB) || (line_byte == CH_CR);
	assign stop   = (line_byte == CH_NUL) || (line_byte == CH_NL);

	assign app      = ((phase_q == PH_LEAD) || (phase_q == PH_INTERP) || (phase_q == PH_MID) ||
		(phase_q == PH_ARG)) && !blank && !stop;
	assign app_arg  = (phase_q == PH_MID) || (phase_q == PH_ARG);
	assign len_base = ((phase_q == PH_LEAD) || (phase_q == PH_MID)) ? '0 : len_q;
	assign cap      = app_arg ? argument_capacity : interp_capacity;
	assign too_long = ({1'b0, len_base} + (CAP_W+1)'(1)) >= {1'b0, cap};

	always_comb begin
		result = '0;
		result.verdict = VERDICT_NOT_SHEBANG;
		unique case (phase_q)
			PH_HASH: begin
				if (line_byte != CH_HASH || at_end) begin
					result.ver_valid = 1'b1;
				end
			end
			PH_BANG: begin
				if (line_byte != CH_BANG) begin
					result.ver_valid = 1'b1;
				end else if (at_end) begin
					result.ver_valid = 1'b1;
					result.verdict   = VERDICT_MALFORMED;
				end
			end
			PH_LEAD: begin
				if ((blank && at_end) || stop) begin
					result.ver_valid = 1'b1;
					result.verdict   = VERDICT_MALFORMED;
				end
			end
			PH_INTERP, PH_MID: begin
				if ((blank && at_end) || stop) begin
					result.ver_valid = 1'b1;
					result.verdict   = VERDICT_INTERP_ONLY;
				end
			end
			PH_ARG: begin
				if ((blank && at_end) || stop) begin
					result.ver_valid = 1'b1;
					result.verdict   = VERDICT_WITH_ARG;
				end
			end
			PH_TRAIL: begin
				if ((blank && at_end) || stop) begin
					result.ver_valid = 1'b1;
					result.verdict   = VERDICT_WITH_ARG;
				end else if (!blank) begin
					result.ver_valid = 1'b1;
					result.verdict   = VERDICT_MALFORMED;
				end
			end
			PH_IGNORE: begin
			end
		endcase
		if (app) begin
			if (too_long) begin
				result.ver_valid = 1'b1;
				result.verdict   = VERDICT_MALFORMED;
			end else begin
				result.tok_valid = 1'b1;
				result.tok_arg   = app_arg;
				result.tok_byte  = line_byte;
				if (at_end) begin
					result.ver_valid = 1'b1;
					result.verdict   = app_arg ? VERDICT_WITH_ARG : VERDICT_INTERP_ONLY;
				end
			end
		end
	end

	always_comb begin
		phase_d = phase_q;
		len_d   = len_q;
		pos_d   = pos_q;
		if (phase_q == PH_IGNORE) begin
			if (line_end) begin
				phase_d = PH_HASH;
				len_d   = '0;
				pos_d   = '0;
			end
		end else begin
			if (pos_q < POS_MAX) begin
				pos_d = pos_q + PW'(1);
			end
			unique case (phase_q)
				PH_HASH:   phase_d = PH_BANG;
				PH_BANG:   phase_d = PH_LEAD;
				PH_INTERP: begin
					if (blank) begin
						phase_d = PH_MID;
						len_d   = '0;
					end
				end
				PH_ARG: begin
					if (blank) begin
						phase_d = PH_TRAIL;
					end
				end
				default: begin
				end
			endcase
			if (result.tok_valid) begin
				len_d   = len_base + CAP_W'(1);
				phase_d = app_arg ? PH_ARG : PH_INTERP;
			end
			if (result.ver_valid) begin
				len_d = '0;
				if (line_end) begin
					phase_d = PH_HASH;
					pos_d   = '0;
				end else begin
					phase_d = PH_IGNORE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HASH;
			len_q   <= '0;
			pos_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			pos_q   <= pos_d;
		end
	end

endmodule

>>> hw/rtl/sbp_checker.sv
// ----------------------------------------------------------------------------
// sbp_port_checker: port-level checks for the shebang line parser
// Watches the result channel; bound to the top level.
// ----------------------------------------------------------------------------
module sbp_port_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic       token_valid,
	input logic       token_is_argument,
	input logic [7:0] token_byte,
	input logic       verdict_valid,
	input logic [1:0] verdict
);

	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (token_valid || verdict_valid))
		else $error("result item carries neither token nor verdict");

	a_arg_needs_tok: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !token_valid) |-> (!token_is_argument && token_byte == 8'h00))
		else $error("token fields set without a token byte");

	a_verdict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !verdict_valid) |-> (verdict == 2'd0))
		else $error("verdict code set without a verdict");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> res_valid)
		else $error("result item dropped while stalled");

endmodule

bind shebang_line_parser sbp_port_checker u_sbp_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.res_valid         (result.valid),
	.res_ready         (result.ready),
	.token_valid       (result.token_valid),
	.token_is_argument (result.token_is_argument),
	.token_byte        (result.token_byte),
	.verdict_valid     (result.verdict_valid),
	.verdict           (result.verdict)
);

>>> bench/sbp_checker.sv
// ----------------------------------------------------------------------------
// sbp_checker: result checker for the shebang line parser
// Watches the line and result channels and the register port, runs its own
// parse of every accepted byte, and compares each result in order.
// ----------------------------------------------------------------------------
module sbp_checker #(
	parameter int LINE_MAX = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	sbp_line_if                           line,
	sbp_result_if                         result,
	input  logic                          wr_en,
	input  logic [sbp_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [sbp_pkg::CAP_W-1:0]     wr_data,
	output int                            mismatches,
	output int                            results_due,
	output int                            token_bytes_seen,
	output int                            verdicts_seen [4]
);
	timeunit 1ns;
	timeprecision 1ps;
	import sbp_pkg::*;

	phase_t  ph;
	int      tok_len;
	int      line_fill;
	int      interp_cap;
	int      arg_cap;
	result_t token_verdict_q [$];
	result_t got;
	result_t want;
	logic    emit;

	task automatic give(inout result_t r, input verdict_t v);
		r.ver_valid = 1'b1;
		r.verdict   = v;
	endtask

	task automatic take_char(input logic arg, input logic [7:0] b, input logic at_end,
		inout result_t r);
		int cap;
		cap = arg ? arg_cap : interp_cap;
		if (tok_len + 1 >= cap) begin
			give(r, VERDICT_MALFORMED);
		end else begin
			r.tok_valid = 1'b1;
			r.tok_arg   = arg;
			r.tok_byte  = b;
			tok_len++;
			ph = arg ? PH_ARG : PH_INTERP;
			if (at_end) begin
				if (arg) give(r, VERDICT_WITH_ARG);
				else give(r, VERDICT_INTERP_ONLY);
			end
		end
	endtask

	task automatic parse_line_byte(input logic [7:0] b, input logic last, output logic hit,
		output result_t r);
		logic at_end;
		logic blank;
		logic stop;
		r   = '0;
		hit = 1'b0;
		if (ph == PH_IGNORE) begin
			if (last) begin
				ph        = PH_HASH;
				line_fill = 0;
				tok_len   = 0;
			end
		end else begin
			at_end = last || (line_fill + 1 >= LINE_MAX - 1);
			if (line_fill < LINE_MAX) line_fill++;
			blank = b == CH_SPACE || b == CH_TAB || b == CH_CR;
			stop  = b == CH_NUL || b == CH_NL;
			case (ph)
				PH_HASH: begin
					if (b != CH_HASH || at_end) give(r, VERDICT_NOT_SHEBANG);
					else ph = PH_BANG;
				end
				PH_BANG: begin
					if (b != CH_BANG) give(r, VERDICT_NOT_SHEBANG);
					else if (at_end) give(r, VERDICT_MALFORMED);
					else ph = PH_LEAD;
				end
				PH_LEAD: begin
					if (blank) begin
						if (at_end) give(r, VERDICT_MALFORMED);
					end else if (stop) begin
						give(r, VERDICT_MALFORMED);
					end else begin
						tok_len = 0;
						take_char(1'b0, b, at_end, r);
					end
				end
				PH_INTERP: begin
					if (blank) begin
						if (at_end) begin
							give(r, VERDICT_INTERP_ONLY);
						end else begin
							ph      = PH_MID;
							tok_len = 0;
						end
					end else if (stop) begin
						give(r, VERDICT_INTERP_ONLY);
					end else begin
						take_char(1'b0, b, at_end, r);
					end
				end
				PH_MID: begin
					if (blank) begin
						if (at_end) give(r, VERDICT_INTERP_ONLY);
					end else if (stop) begin
						give(r, VERDICT_INTERP_ONLY);
					end else begin
						tok_len = 0;
						take_char(1'b1, b, at_end, r);
					end
				end
				PH_ARG: begin
					if (blank) begin
						if (at_end) give(r, VERDICT_WITH_ARG);
						else ph = PH_TRAIL;
					end else if (stop) begin
						give(r, VERDICT_WITH_ARG);
					end else begin
						take_char(1'b1, b, at_end, r);
					end
				end
				default: begin
					if (blank) begin
						if (at_end) give(r, VERDICT_WITH_ARG);
					end else if (stop) begin
						give(r, VERDICT_WITH_ARG);
					end else begin
						give(r, VERDICT_MALFORMED);
					end
				end
			endcase
			if (r.ver_valid) begin
				tok_len = 0;
				if (last) begin
					ph        = PH_HASH;
					line_fill = 0;
				end else begin
					ph = PH_IGNORE;
				end
			end
			hit = r.tok_valid || r.ver_valid;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph               = PH_HASH;
			tok_len          = 0;
			line_fill        = 0;
			interp_cap       = 128;
			arg_cap          = 128;
			token_verdict_q.delete();
			mismatches       = 0;
			results_due      = 0;
			token_bytes_seen = 0;
			foreach (verdicts_seen[i]) verdicts_seen[i] = 0;
		end else begin
			if (wr_en) begin
				if (wr_index == CFG_INTERP_CAP) interp_cap = int'(wr_data);
				else arg_cap = int'(wr_data);
			end
			if (result.valid && result.ready) begin
				got.tok_valid = result.token_valid;
				got.tok_arg   = result.token_is_argument;
				got.tok_byte  = result.token_byte;
				got.ver_valid = result.verdict_valid;
				got.verdict   = verdict_t'(result.verdict);
				if (got.tok_valid === 1'b1) token_bytes_seen++;
				if (got.ver_valid === 1'b1) verdicts_seen[got.verdict]++;
				if (token_verdict_q.size() == 0) begin
					if (mismatches < 10)
						$display("[chk] %0t: unexpected result tok %b/%b/%02h verdict %b/%0d",
							$realtime, got.tok_valid, got.tok_arg, got.tok_byte,
							got.ver_valid, got.verdict);
					mismatches++;
				end else begin
					want = token_verdict_q.pop_front();
					if (got.tok_valid !== want.tok_valid || got.tok_arg !== want.tok_arg ||
						got.tok_byte !== want.tok_byte || got.ver_valid !== want.ver_valid ||
						got.verdict !== want.verdict) begin
						if (mismatches < 10)
							$display({"[chk] %0t: expected tok %b/%b/%02h verdict %b/%0d,",
								" got tok %b/%b/%02h verdict %b/%0d"}, $realtime,
								want.tok_valid, want.tok_arg, want.tok_byte, want.ver_valid,
								want.verdict, got.tok_valid, got.tok_arg, got.tok_byte,
								got.ver_valid, got.verdict);
						mismatches++;
					end
				end
			end
			if (line.valid && line.ready) begin
				parse_line_byte(line.line_byte, line.line_end, emit, want);
				if (emit) token_verdict_q.push_back(want);
			end
			results_due = token_verdict_q.size();
		end
	end

endmodule

>>> bench/tb_shebang_line_parser.sv
// ----------------------------------------------------------------------------
// tb_shebang_line_parser: testbench top for the shebang line parser
// Feeds directed and random first lines under several buffer capacities,
// with bursty input, a stalling consumer and one long consumer hold-off.
// ----------------------------------------------------------------------------
module tb_shebang_line_parser;
	timeunit 1ns;
	timeprecision 1ps;
	import sbp_pkg::*;

	localparam int LINE_MAX    = 128;
	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASES      = 9;
	localparam int PHASE_ITEMS = 160;
	localparam int HOLD_PHASE  = 7;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              wr_en;
	cfg_index_t        wr_index;
	logic [CAP_W-1:0]  wr_data;

	int mismatches;
	int results_due;
	int token_bytes_seen;
	int verdicts_seen [4];

	int icap_tab [PHASES] = '{128, 1, 2, 0, 5, 128, 12, 128, 77};
	int acap_tab [PHASES] = '{128, 128, 3, 200, 255, 1, 9, 128, 0};

	logic [7:0] line_buf [$];
	int icap;
	int acap;
	int burst_left;
	int items_sent;
	int lines_sent;
	int phase_items;
	int hold_ticket;
	int hold_served;
	int hold_left;
	int stall_mode;
	int mode_left;
	logic [7:0] stall_mask;
	int cycles;

	sbp_line_if   line_ch ();
	sbp_result_if result_ch ();

	shebang_line_parser #(.LINE_MAX(LINE_MAX)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.line     (line_ch),
		.result   (result_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	sbp_checker #(.LINE_MAX(LINE_MAX)) chk (
		.clk              (clk),
		.arst_n           (arst_n),
		.line             (line_ch),
		.result           (result_ch),
		.wr_en            (wr_en),
		.wr_index         (wr_index),
		.wr_data          (wr_data),
		.mismatches       (mismatches),
		.results_due      (results_due),
		.token_bytes_seen (token_bytes_seen),
		.verdicts_seen    (verdicts_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[tb] timeout after %0d cycles, %0d results outstanding", cycles,
				results_due);
			$display("[shebang_line_parser] ERROR");
			$finish;
		end
	end

	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (hold_ticket != hold_served) begin
				hold_served = hold_ticket;
				hold_left   = 79;
				result_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					stall_mode = $urandom_range(0, 3);
					mode_left  = $urandom_range(20, 150);
					stall_mask = 8'($urandom_range(0, 255)) | 8'h01;
				end
				mode_left--;
				case (stall_mode)
					0: result_ch.ready <= 1'b1;
					1: result_ch.ready <= 1'($urandom_range(0, 1));
					2: result_ch.ready <= ($urandom_range(0, 7) != 0);
					default: begin
						result_ch.ready <= stall_mask[0];
						stall_mask = {stall_mask[0], stall_mask[7:1]};
					end
				endcase
			end
		end
	end

	function automatic logic [7:0] token_char();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		while (c inside {CH_SPACE, CH_TAB, CH_CR, CH_NUL, CH_NL}) c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	function automatic void add_token(int n);
		repeat (n) line_buf.push_back(token_char());
	endfunction

	function automatic void add_blanks(int n);
		repeat (n) begin
			case ($urandom_range(0, 2))
				0: line_buf.push_back(CH_SPACE);
				1: line_buf.push_back(CH_TAB);
				default: line_buf.push_back(CH_CR);
			endcase
		end
	endfunction

	function automatic void add_noise(int n);
		repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
	endfunction

	function automatic int token_len(int cap);
		int n;
		case ($urandom_range(0, 5))
			0: n = cap - 2;
			1: n = cap - 1;
			2: n = cap;
			default: n = $urandom_range(1, 8);
		endcase
		if (n < 1) n = 1;
		if (n > 70) n = 70;
		return n;
	endfunction

	function automatic void compose_line();
		int kind;
		int target;
		kind = $urandom_range(0, 99);
		if (kind < 65) begin
			line_buf.push_back(CH_HASH);
			line_buf.push_back(CH_BANG);
			add_blanks($urandom_range(0, 2));
			add_token(token_len(icap));
			if ($urandom_range(0, 9) < 6) begin
				add_blanks($urandom_range(1, 2));
				add_token(token_len(acap));
			end
			add_blanks($urandom_range(0, 2));
			case ($urandom_range(0, 4))
				0: ;
				1: begin
					line_buf.push_back(CH_NL);
					add_noise($urandom_range(0, 3));
				end
				2: line_buf.push_back(CH_NUL);
				3: begin
					add_blanks($urandom_range(1, 2));
					add_token($urandom_range(1, 3));
					add_noise($urandom_range(0, 2));
				end
				default: line_buf.push_back(CH_CR);
			endcase
		end else if (kind < 75) begin
			if ($urandom_range(0, 1)) line_buf.push_back(CH_HASH);
			add_noise($urandom_range(1, 6));
		end else if (kind < 85) begin
			if ($urandom_range(0, 1)) begin
				line_buf.push_back(CH_HASH);
				line_buf.push_back(CH_BANG);
			end
			add_noise($urandom_range(1, 12));
		end else if (kind < 92) begin
			line_buf.push_back(CH_HASH);
			line_buf.push_back(CH_BANG);
			add_blanks($urandom_range(0, 3));
			if ($urandom_range(0, 1)) line_buf.push_back($urandom_range(0, 1) ? CH_NL : CH_NUL);
			add_noise($urandom_range(0, 2));
		end else begin
			target = $urandom_range(126, 140);
			line_buf.push_back(CH_HASH);
			line_buf.push_back(CH_BANG);
			add_token($urandom_range(40, 70));
			add_blanks(1);
			add_token($urandom_range(40, 70));
			while (line_buf.size() < target) add_noise(1);
		end
	endfunction

	task automatic send_item(input logic [7:0] b, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				line_ch.valid <= 1'b0;
			end
			burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 20);
		end
		@(negedge clk);
		line_ch.valid     <= 1'b1;
		line_ch.line_byte <= b;
		line_ch.line_end  <= last;
		do @(posedge clk); while (line_ch.ready !== 1'b1);
		burst_left--;
		items_sent++;
		phase_items++;
	endtask

	task automatic send_line();
		foreach (line_buf[i]) send_item(line_buf[i], i == line_buf.size() - 1);
		line_buf.delete();
		lines_sent++;
	endtask

	task automatic settle();
		@(negedge clk);
		line_ch.valid <= 1'b0;
		while (results_due != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_caps(input int i_cap, input int a_cap);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= CFG_INTERP_CAP;
		wr_data  <= i_cap[CAP_W-1:0];
		@(negedge clk);
		wr_index <= CFG_ARG_CAP;
		wr_data  <= a_cap[CAP_W-1:0];
		@(negedge clk);
		wr_en <= 1'b0;
		icap = i_cap;
		acap = a_cap;
	endtask

	initial begin
		line_ch.valid     <= 1'b0;
		line_ch.line_byte <= '0;
		line_ch.line_end  <= 1'b0;
		wr_en             <= 1'b0;
		wr_index          <= CFG_INTERP_CAP;
		wr_data           <= '0;
		arst_n            <= 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		icap = 128;
		acap = 128;

		line_buf = '{CH_NUL};
		send_line();
		line_buf = '{CH_HASH};
		send_line();
		line_buf = '{CH_HASH, CH_BANG};
		send_line();
		line_buf = '{CH_HASH, CH_BANG, CH_SPACE, CH_TAB, CH_NL, "q"};
		send_line();
		line_buf = '{CH_HASH, CH_BANG, 8'hFF};
		send_line();
		line_buf = '{CH_HASH, CH_BANG, "a", CH_SPACE, "b", CH_CR, "c"};
		send_line();
		line_buf = '{CH_HASH, CH_BANG, "a", CH_TAB, "b", CH_NUL};
		send_line();

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				settle();
				write_caps(icap_tab[p], acap_tab[p]);
			end
			phase_items = 0;
			if (p == HOLD_PHASE) begin
				hold_ticket++;
				line_buf = '{CH_HASH, CH_BANG};
				add_token(50);
				add_blanks(1);
				add_token(40);
				send_line();
			end
			while (phase_items < PHASE_ITEMS) begin
				compose_line();
				send_line();
			end
		end
		settle();
		repeat (8) @(negedge clk);

		$display("[tb] %0d bytes in %0d lines over %0d capacity settings, %0d consumer hold-off",
			items_sent, lines_sent, PHASES, hold_ticket);
		$display("[tb] verdicts none/interp/arg/malformed %0d/%0d/%0d/%0d, token bytes %0d",
			verdicts_seen[0], verdicts_seen[1], verdicts_seen[2], verdicts_seen[3],
			token_bytes_seen);
		if (results_due != 0) $display("[tb] %0d results never arrived", results_due);
		if (mismatches == 0 && results_due == 0) begin
			$display("[shebang_line_parser] OK");
		end else begin
			$display("[shebang_line_parser] ERROR");
		end
		$finish;
	end

endmodule
